### sv/mvt_pkg.sv
// mvt_pkg: shared types, constants and op codes for the matrix vector transform unit
// no dependencies; used by matrix_vector_transform_unit, mvt_checker and the testbench
package mvt_pkg;

  // active dimension and fixed point format
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ELEMS  = 16;
  localparam int LANES  = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [3:0]        elem_idx_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_VEC4  = 2'd1,
    OP_POINT = 2'd2
  } op_t;

  // 1.0 in the fixed point format, used for w in point mode
  localparam word_t ONE_FIXED = word_t'(64'sd1 <<< FRAC_BITS);

  // clamp bounds of the result word
  localparam sum_t WORD_MAX = sum_t'(64'sd2147483647);
  localparam sum_t WORD_MIN = sum_t'(-64'sd2147483648);

endpackage

### sv/matrix_vector_transform_unit.sv
// matrix_vector_transform_unit: 4x4 column-major Q16.16 matrix times a vec4 or a point
// depends on mvt_pkg for types, format constants and op codes
//
// throughput: one word per cycle unless the result side stalls; a transform word is
//   registered in stage 1, then sixteen parallel 32x32 multipliers feed a registered
//   product bank, then one adder tree and clamp per row feed the result register
// element writes take effect at their accept edge and produce no result word
// reset (rst, synchronous): clears the matrix to zero and all stage valid bits
module matrix_vector_transform_unit (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          op,
  input  logic [3:0]          elem_index,
  input  logic signed [31:0]  elem_value,
  input  logic signed [31:0]  vec_x,
  input  logic signed [31:0]  vec_y,
  input  logic signed [31:0]  vec_z,
  input  logic signed [31:0]  vec_w,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [31:0]  out_w,
  output logic                saturated
);

  // matrix storage, column*4 + row
  mvt_pkg::word_t matrix [mvt_pkg::ELEMS];

  // stage 1: registered vector of a transform word
  logic           s1_valid;
  mvt_pkg::word_t s1_vec [mvt_pkg::LANES];

  // stage 2: registered products, [row][column]
  logic           s2_valid;
  mvt_pkg::prod_t prod [mvt_pkg::LANES][mvt_pkg::LANES];

  // result register
  mvt_pkg::word_t res [mvt_pkg::LANES];
  logic           res_sat;

  // per-stage advance, back pressure ripples from the result side
  logic s3_ready;
  logic s2_ready;
  logic s1_ready;
  logic in_accept;

  assign s3_ready  = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // op decode
  mvt_pkg::op_t in_op;
  logic         is_write;
  logic         is_xform;
  mvt_pkg::word_t w_in;

  assign in_op = mvt_pkg::op_t'(op);

  always_comb begin
    is_write = 1'b0;
    is_xform = 1'b0;
    w_in     = vec_w;
    unique case (in_op)
      mvt_pkg::OP_WRITE: begin
        is_write = 1'b1;
      end
      mvt_pkg::OP_VEC4: begin
        is_xform = 1'b1;
      end
      mvt_pkg::OP_POINT: begin
        is_xform = 1'b1;
        w_in     = mvt_pkg::ONE_FIXED;
      end
      default: begin
        // unused code: dropped
        is_write = 1'b0;
      end
    endcase
  end

  // element writes land at the accept edge; a transform still in stage 1 multiplies
  // on that same edge and so sees the matrix as it was before the write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mvt_pkg::ELEMS; i++) begin
        matrix[i] <= '0;
      end
    end else if (in_accept && is_write) begin
      matrix[elem_index] <= elem_value;
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_accept && is_xform;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_accept && is_xform) begin
      s1_vec[0] <= vec_x;
      s1_vec[1] <= vec_y;
      s1_vec[2] <= vec_z;
      s1_vec[3] <= w_in;
    end
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // stage 2: all sixteen products at once, products outside the active square are zero
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      for (int r = 0; r < mvt_pkg::LANES; r++) begin
        for (int c = 0; c < mvt_pkg::LANES; c++) begin
          if (r < mvt_pkg::DIM && c < mvt_pkg::DIM) begin
            prod[r][c] <= mvt_pkg::prod_t'(matrix[mvt_pkg::elem_idx_t'(c * 4 + r)])
                        * mvt_pkg::prod_t'(s1_vec[c]);
          end else begin
            prod[r][c] <= '0;
          end
        end
      end
    end
  end

  // row sums, floor shift and clamp
  mvt_pkg::sum_t  row_sum   [mvt_pkg::LANES];
  mvt_pkg::sum_t  row_shift [mvt_pkg::LANES];
  mvt_pkg::word_t res_next  [mvt_pkg::LANES];
  logic           sat_next;

  always_comb begin
    sat_next = 1'b0;
    for (int r = 0; r < mvt_pkg::LANES; r++) begin
      row_sum[r] = (mvt_pkg::sum_t'(prod[r][0]) + mvt_pkg::sum_t'(prod[r][1]))
                 + (mvt_pkg::sum_t'(prod[r][2]) + mvt_pkg::sum_t'(prod[r][3]));
      // arithmetic shift of the exact sum rounds toward minus infinity
      row_shift[r] = row_sum[r] >>> mvt_pkg::FRAC_BITS;
      if (r >= mvt_pkg::DIM) begin
        res_next[r] = '0;
      end else if (row_shift[r] > mvt_pkg::WORD_MAX) begin
        res_next[r] = mvt_pkg::word_t'(mvt_pkg::WORD_MAX);
        sat_next    = 1'b1;
      end else if (row_shift[r] < mvt_pkg::WORD_MIN) begin
        res_next[r] = mvt_pkg::word_t'(mvt_pkg::WORD_MIN);
        sat_next    = 1'b1;
      end else begin
        res_next[r] = row_shift[r][mvt_pkg::WORD_W-1:0];
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      for (int r = 0; r < mvt_pkg::LANES; r++) begin
        res[r] <= res_next[r];
      end
      res_sat <= sat_next;
    end
  end

  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];
  assign saturated = res_sat;

  // input only stalls when every stage holds a word and the result side is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
    else $error("input stalled with a free pipeline slot");

  // a saturated result has at least one clamped component
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
       out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
       out_z == 32'sh7fffffff || out_z == 32'sh80000000 ||
       out_w == 32'sh7fffffff || out_w == 32'sh80000000))
    else $error("saturated flag without a clamped component");

  // an accepted element write is visible in the matrix on the next cycle
  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_write) |=> (matrix[$past(elem_index)] == $past(elem_value)))
    else $error("matrix element write lost");

  // a transform word in stage 1 moves to stage 2 whenever stage 2 can take it
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_ready) |=> s2_valid)
    else $error("stage 1 word dropped");

endmodule

### test/mvt_checker.sv
// mvt_checker: watches both channels of the matrix vector transform unit
// keeps its own matrix copy, predicts each transform and compares result words; uses mvt_pkg
`timescale 1ns / 1ps

module mvt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic signed [31:0] out_w,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending_results,
  output int                 results_checked,
  output int                 clamped_results
);

  typedef struct packed {
    logic                                       clamped;
    mvt_pkg::word_t [mvt_pkg::LANES-1:0]        comp;
  } transform_t;

  mvt_pkg::word_t matrix_copy [mvt_pkg::ELEMS];
  transform_t     transformed_q [$];
  int             mismatches = 0;
  int             checked = 0;
  int             clamped = 0;

  task automatic report_mismatch(input string what, input mvt_pkg::word_t got,
                                 input mvt_pkg::word_t want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
  endtask

  // matrix copy times one vector, exact sums, floor to the fixed point grid, clamp
  function automatic transform_t apply_matrix(input mvt_pkg::word_t vx,
                                              input mvt_pkg::word_t vy,
                                              input mvt_pkg::word_t vz,
                                              input mvt_pkg::word_t vw,
                                              input logic as_point);
    mvt_pkg::word_t vec [mvt_pkg::LANES];
    transform_t     res;
    mvt_pkg::prod_t prod;
    mvt_pkg::sum_t  acc;
    int             r;
    int             c;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = as_point ? mvt_pkg::ONE_FIXED : vw;
    res = '0;
    for (r = 0; r < mvt_pkg::LANES; r++) begin
      if (r < mvt_pkg::DIM) begin
        acc = '0;
        for (c = 0; c < mvt_pkg::DIM && c < mvt_pkg::LANES; c++) begin
          prod = mvt_pkg::prod_t'(matrix_copy[c * 4 + r]) * mvt_pkg::prod_t'(vec[c]);
          acc  = acc + mvt_pkg::sum_t'(prod);
        end
        acc = acc >>> mvt_pkg::FRAC_BITS;
        if (acc > mvt_pkg::WORD_MAX) begin
          res.comp[r] = mvt_pkg::word_t'(mvt_pkg::WORD_MAX);
          res.clamped = 1'b1;
        end else if (acc < mvt_pkg::WORD_MIN) begin
          res.comp[r] = mvt_pkg::word_t'(mvt_pkg::WORD_MIN);
          res.clamped = 1'b1;
        end else begin
          res.comp[r] = mvt_pkg::word_t'(acc);
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    transform_t seen;
    transform_t want;
    int         r;
    if (rst) begin
      foreach (matrix_copy[i]) matrix_copy[i] = '0;
      transformed_q.delete();
    end else begin
      // result side first: a word accepted now cannot have produced this result
      if (out_valid && !out_stall) begin
        seen.comp[0] = out_x;
        seen.comp[1] = out_y;
        seen.comp[2] = out_z;
        seen.comp[3] = out_w;
        seen.clamped = saturated;
        if (transformed_q.size() == 0) begin
          report_mismatch("result word with nothing pending, x lane", out_x, '0);
        end else begin
          want = transformed_q.pop_front();
          checked++;
          if (want.clamped) clamped++;
          for (r = 0; r < mvt_pkg::LANES; r++)
            if (seen.comp[r] !== want.comp[r])
              report_mismatch($sformatf("lane %0d", r), seen.comp[r], want.comp[r]);
          if (seen.clamped !== want.clamped)
            report_mismatch("saturated flag", mvt_pkg::word_t'(seen.clamped),
                            mvt_pkg::word_t'(want.clamped));
        end
      end
      if (in_valid && !in_stall) begin
        case (op)
          mvt_pkg::OP_WRITE: matrix_copy[elem_index] = elem_value;
          mvt_pkg::OP_VEC4:
            transformed_q.push_back(apply_matrix(vec_x, vec_y, vec_z, vec_w, 1'b0));
          mvt_pkg::OP_POINT:
            transformed_q.push_back(apply_matrix(vec_x, vec_y, vec_z, vec_w, 1'b1));
          default: ;  // unused code, no effect
        endcase
      end
    end
    fail_count      <= mismatches;
    pending_results <= transformed_q.size();
    results_checked <= checked;
    clamped_results <= clamped;
  end

endmodule

### test/tb_matrix_vector_transform_unit.sv
// tb_matrix_vector_transform_unit: stimulus and verdict for the matrix vector transform unit
// depends on mvt_pkg, matrix_vector_transform_unit and mvt_checker
`timescale 1ns / 1ps

module tb_matrix_vector_transform_unit;

  // code that the unit must ignore, outside op_t
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // word values used by the directed part
  localparam mvt_pkg::word_t W_MAX   = 32'sh7fff_ffff;
  localparam mvt_pkg::word_t W_MIN   = 32'sh8000_0000;
  localparam mvt_pkg::word_t NEG_ONE = -mvt_pkg::ONE_FIXED;

  // minimum count of transform and write words, directed part included, ignored codes not counted
  localparam int TOTAL_WORDS = 1200;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = mvt_pkg::OP_WRITE;
  logic [3:0]         elem_index = '0;
  logic signed [31:0] elem_value = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic signed [31:0] vec_w = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               saturated;

  // from the checker
  int fail_count;
  int pending_results;
  int results_checked;
  int clamped_results;

  // sender pacing and bookkeeping
  int words_sent = 0;
  int elem_writes = 0;
  int burst_left = 0;

  // receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  matrix_vector_transform_unit u_top (.*);

  mvt_checker u_check (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver: stall behavior changes at random intervals, including long clean stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_left[3];  // regular blocks, following bit 3 of the countdown
    endcase
  end

  // values within +-4.0, a share set by spread over the full range, now and then an extreme
  function automatic mvt_pkg::word_t pick_word(input int spread);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < spread) return mvt_pkg::word_t'($urandom);
    if (roll < spread + 8) begin
      case ($urandom_range(0, 4))
        0:       return W_MAX;
        1:       return W_MIN;
        2:       return mvt_pkg::ONE_FIXED;
        3:       return NEG_ONE;
        default: return '0;
      endcase
    end
    return mvt_pkg::word_t'($signed($urandom) >>> 13);
  endfunction

  // present one word, hold it through stalls, then pace the sender in bursts
  task automatic send_word(input logic [1:0] code, input logic [3:0] idx,
                           input mvt_pkg::word_t value,
                           input mvt_pkg::word_t x, input mvt_pkg::word_t y,
                           input mvt_pkg::word_t z, input mvt_pkg::word_t w);
    int gap;
    op         <= code;
    elem_index <= idx;
    elem_value <= value;
    vec_x      <= x;
    vec_y      <= y;
    vec_z      <= z;
    vec_w      <= w;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (code != OP_UNUSED) words_sent++;
    if (code == mvt_pkg::OP_WRITE) elem_writes++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap between bursts, sometimes none at all
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  // element write, vector fields carry noise
  task automatic load_elem(input logic [3:0] idx, input mvt_pkg::word_t value);
    send_word(mvt_pkg::OP_WRITE, idx, value, mvt_pkg::word_t'($urandom),
              mvt_pkg::word_t'($urandom), mvt_pkg::word_t'($urandom),
              mvt_pkg::word_t'($urandom));
  endtask

  // transform word, element fields carry noise
  task automatic transform(input logic [1:0] code, input mvt_pkg::word_t x,
                           input mvt_pkg::word_t y, input mvt_pkg::word_t z,
                           input mvt_pkg::word_t w);
    send_word(code, 4'($urandom), mvt_pkg::word_t'($urandom), x, y, z, w);
  endtask

  initial begin
    int spread;
    int run_len;
    int roll;
    int i;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: matrix still zero after reset
    transform(mvt_pkg::OP_VEC4, mvt_pkg::ONE_FIXED, NEG_ONE, W_MAX, W_MIN);
    // extreme elements on the diagonal plus one small off-diagonal term in row 0
    load_elem(4'd0, W_MAX);
    load_elem(4'd5, W_MIN);
    load_elem(4'd10, mvt_pkg::ONE_FIXED);
    load_elem(4'd15, NEG_ONE);
    load_elem(4'd12, 32'sd1);
    // clamp high and low in different rows
    transform(mvt_pkg::OP_VEC4, W_MAX, W_MAX, W_MAX, W_MAX);
    transform(mvt_pkg::OP_VEC4, W_MIN, W_MIN, W_MIN, W_MIN);
    // point mode must drop the given w
    transform(mvt_pkg::OP_POINT, mvt_pkg::ONE_FIXED, mvt_pkg::ONE_FIXED,
              mvt_pkg::ONE_FIXED, W_MIN);
    // negative product that is not a multiple of the grid, floor rounding
    transform(mvt_pkg::OP_VEC4, -32'sd1, 32'sd0, 32'sd0, 32'sd0);
    // unused code must change nothing and return nothing
    send_word(OP_UNUSED, 4'd3, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX);
    transform(mvt_pkg::OP_VEC4, '0, '0, '0, '0);
    // overwrite an element that was already loaded
    load_elem(4'd15, 32'sh0001_8000);
    transform(mvt_pkg::OP_POINT, W_MIN, W_MAX, NEG_ONE, mvt_pkg::ONE_FIXED);
    load_elem(4'd5, '0);
    load_elem(4'd0, -32'sd1);
    transform(mvt_pkg::OP_VEC4, 32'sd1, -32'sd1, W_MAX, W_MIN);
    // zero point still picks up column 3
    transform(mvt_pkg::OP_POINT, '0, '0, '0, '0);

    // random: phases with their own value spread, often starting from a freshly loaded matrix
    while (words_sent < TOTAL_WORDS) begin
      spread = $urandom_range(0, 60);
      if ($urandom_range(0, 3) == 0) begin
        for (i = 0; i < mvt_pkg::ELEMS; i++) load_elem(4'(i), pick_word(spread));
      end
      run_len = $urandom_range(8, 48);
      repeat (run_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 10)
          load_elem(4'($urandom), pick_word(spread));
        else if (roll < 14)
          send_word(OP_UNUSED, 4'($urandom), mvt_pkg::word_t'($urandom),
                    mvt_pkg::word_t'($urandom), mvt_pkg::word_t'($urandom),
                    mvt_pkg::word_t'($urandom), mvt_pkg::word_t'($urandom));
        else
          transform((roll < 57) ? mvt_pkg::OP_VEC4 : mvt_pkg::OP_POINT,
                    pick_word(spread), pick_word(spread),
                    pick_word(spread), pick_word(spread));
      end
    end
    in_valid <= 1'b0;

    // drain: first edge lets the checker count catch up with the last word
    do @(posedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);

    $display("sent %0d words, %0d of them element writes, plus ignored codes",
             words_sent, elem_writes);
    $display("checked %0d transform results, %0d with clamped lanes",
             results_checked, clamped_results);
    if (fail_count == 0 && pending_results == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("timeout with %0d results still pending", pending_results);
    $display("Test completed with failures");
    $finish;
  end

endmodule
